// ----- hdl/ogmf_pkg.sv -----
// ----------------------------------------------------------------------------
// ogmf_pkg
// shared types and constants of the occupancy grid max fusion block
// ----------------------------------------------------------------------------
package ogmf_pkg;

	localparam int GridW   = 256;
	localparam int GridH   = 256;
	localparam int Cells   = GridW * GridH;
	localparam int IdxW    = $clog2(Cells);
	localparam int CfgIdxW = 3;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_WIDTH    = 3'd0,
		CFG_HEIGHT   = 3'd1,
		CFG_GORG_X   = 3'd2,
		CFG_GORG_Y   = 3'd3,
		CFG_CPM      = 3'd4,
		CFG_LRES     = 3'd5,
		CFG_LORG_X   = 3'd6,
		CFG_LORG_Y   = 3'd7
	} cfg_idx_t;

	typedef enum logic {
		REQ_MERGE = 1'b0,
		REQ_READ  = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		CLR_RUN  = 2'd0,
		CLR_DONE = 2'd1
	} clr_state_t;

	// command handed from the front part to the back part
	typedef struct packed {
		logic            wr;     // merge that lands in the grid
		logic            rd;     // read of the store
		logic [IdxW-1:0] idx;
		logic [6:0]      cost;
	} cmd_t;

	typedef struct packed {
		logic        written;
		logic [15:0] cell_index;
		logic [6:0]  cell_value;
	} res_t;

	typedef struct packed {
		logic         req_type;
		logic [9:0]   local_col;
		logic [9:0]   local_row;
		logic signed [7:0]  cell_cost;
		logic signed [31:0] robot_x;
		logic signed [31:0] robot_y;
		logic signed [15:0] cos_heading;
		logic signed [15:0] sin_heading;
		logic [15:0]  read_index;
	} req_item_t;

	typedef struct packed {
		logic [8:0]         global_width;
		logic [8:0]         global_height;
		logic signed [31:0] global_origin_x;
		logic signed [31:0] global_origin_y;
		logic [31:0]        global_cells_per_meter;
		logic [31:0]        local_resolution;
		logic signed [31:0] loc_org_x;
		logic signed [31:0] loc_org_y;
	} cfg_t;

endpackage

// ----- hdl/ogmf_if.sv -----
// ----------------------------------------------------------------------------
// ogmf channel interfaces
// valid/ready channels for requests, results and configuration writes
// ----------------------------------------------------------------------------
interface ogmf_req_if;
	import ogmf_pkg::*;
	logic      valid;
	logic      ready;
	req_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ogmf_res_if;
	import ogmf_pkg::*;
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ogmf_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// ----- hdl/ogmf_front.sv -----
// ----------------------------------------------------------------------------
// ogmf_front
// sequential transform of a merge cell into a global grid index; reads pass their index through
// ----------------------------------------------------------------------------
module ogmf_front import ogmf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  req_item_t  in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output cmd_t       out_cmd,
	output logic [15:0] out_ridx
);
	// one item at a time through seven stages
	logic [2:0] stg_q;
	logic       busy_q;
	req_item_t  it_q;
	logic signed [43:0] lx_q, ly_q;
	logic signed [63:0] p0_q, p1_q, p2_q, p3_q;
	logic signed [63:0] wx_q, wy_q;
	logic [63:0] dx_q, dy_q;
	logic        neg_q;
	logic [63:0] hx_q, lxp_q, hy_q, lyp_q;
	logic [8:0]  gx_q, gy_q;
	logic        drop_q;
	logic [16:0] idx_q;
	logic        done_q;

	logic [8:0] w_eff, h_eff;
	assign w_eff = (cfg.global_width  > 9'(GridW)) ? 9'(GridW) : cfg.global_width;
	assign h_eff = (cfg.global_height > 9'(GridH)) ? 9'(GridH) : cfg.global_height;

	assign in_ready  = !busy_q;
	assign out_valid = done_q;

	always_comb begin
		out_cmd      = '0;
		out_ridx     = it_q.read_index;
		out_cmd.idx  = idx_q[IdxW-1:0];
		out_cmd.cost = it_q.cell_cost[6:0];
		if (it_q.req_type == REQ_READ) begin
			out_cmd.rd  = 1'b1;
			out_cmd.idx = it_q.read_index[IdxW-1:0];
		end else begin
			out_cmd.wr = !drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			stg_q  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				busy_q <= 1'b1;
				stg_q  <= 3'd0;
			end else if (busy_q && !done_q) begin
				if (stg_q == 3'd6) done_q <= 1'b1;
				else stg_q <= stg_q + 3'd1;
			end else if (done_q && out_ready) begin
				done_q <= 1'b0;
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) it_q <= in_data;
		if (busy_q && !done_q) begin
			unique case (stg_q)
				3'd0: begin
					lx_q <= 44'(cfg.loc_org_x) + 44'(signed'({1'b0,
						(64'({it_q.local_col, 1'b1}) * 64'(cfg.local_resolution)) >> 1}));
					ly_q <= 44'(cfg.loc_org_y) + 44'(signed'({1'b0,
						(64'({it_q.local_row, 1'b1}) * 64'(cfg.local_resolution)) >> 1}));
				end
				3'd1: begin
					p0_q <= 64'(lx_q) * 64'(it_q.cos_heading);
					p1_q <= 64'(ly_q) * 64'(it_q.sin_heading);
					p2_q <= 64'(lx_q) * 64'(it_q.sin_heading);
					p3_q <= 64'(ly_q) * 64'(it_q.cos_heading);
				end
				3'd2: begin
					wx_q <= 64'(it_q.robot_x) + ((p0_q - p1_q) >>> 14);
					wy_q <= 64'(it_q.robot_y) + ((p2_q + p3_q) >>> 14);
				end
				3'd3: begin
					dx_q  <= 64'(wx_q - 64'(cfg.global_origin_x));
					dy_q  <= 64'(wy_q - 64'(cfg.global_origin_y));
					neg_q <= (wx_q < 64'(cfg.global_origin_x)) ||
						(wy_q < 64'(cfg.global_origin_y));
				end
				3'd4: begin
					hx_q  <= (dx_q >> 16) * 64'(cfg.global_cells_per_meter);
					lxp_q <= ((dx_q & 64'hFFFF) * 64'(cfg.global_cells_per_meter)) >> 16;
					hy_q  <= (dy_q >> 16) * 64'(cfg.global_cells_per_meter);
					lyp_q <= ((dy_q & 64'hFFFF) * 64'(cfg.global_cells_per_meter)) >> 16;
				end
				3'd5: begin
					logic [63:0] sx, sy;
					sx = (hx_q + lxp_q) >> 16;
					sy = (hy_q + lyp_q) >> 16;
					gx_q   <= sx[8:0];
					gy_q   <= sy[8:0];
					drop_q <= neg_q || it_q.cell_cost[7] ||
						(sx >= 64'(w_eff)) || (sy >= 64'(h_eff));
				end
				default: begin
					idx_q <= 17'(gy_q) * 17'(w_eff) + 17'(gx_q);
				end
			endcase
		end
	end
endmodule

// ----- hdl/ogmf_back.sv -----
// ----------------------------------------------------------------------------
// ogmf_back
// global cost store with clearing pass and max merge
// ----------------------------------------------------------------------------
module ogmf_back import ogmf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	output logic        clr_busy,
	input  logic        in_valid,
	output logic        in_ready,
	input  cmd_t        in_cmd,
	input  logic [15:0] in_ridx,
	output logic        out_valid,
	input  logic        out_ready,
	output res_t        out_data
);
	logic [6:0] mem [Cells];
	clr_state_t st_q, st_d;
	logic [IdxW-1:0] clr_q;
	logic       ph_q;    // 0 idle, 1 read issued
	cmd_t       c_q;
	logic [15:0] ri_q;
	logic [6:0] rd_q;
	logic       ov_q;
	res_t       od_q;

	assign clr_busy = (st_q == CLR_RUN);
	assign in_ready = !clr_busy && !ph_q && !ov_q;
	assign out_valid = ov_q;
	assign out_data  = od_q;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			CLR_RUN:  if (clr_q == IdxW'(Cells - 1)) st_d = CLR_DONE;
			default:  st_d = CLR_DONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= CLR_RUN;
			clr_q <= '0;
			ph_q  <= 1'b0;
			ov_q  <= 1'b0;
		end else begin
			st_q <= st_d;
			if (clr_busy) clr_q <= clr_q + IdxW'(1);
			if (in_valid && in_ready) ph_q <= 1'b1;
			else if (ph_q) begin
				ph_q <= 1'b0;
				ov_q <= 1'b1;
			end else if (ov_q && out_ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			c_q  <= in_cmd;
			ri_q <= in_ridx;
			rd_q <= mem[in_cmd.idx];
		end
		if (clr_busy) mem[clr_q] <= '0;
		else if (ph_q && c_q.wr) mem[c_q.idx] <= (c_q.cost > rd_q) ? c_q.cost : rd_q;
		if (ph_q) begin
			od_q.written <= c_q.wr;
			if (c_q.rd) begin
				od_q.cell_index <= ri_q;
				od_q.cell_value <= rd_q;
			end else if (c_q.wr) begin
				od_q.cell_index <= 16'(c_q.idx);
				od_q.cell_value <= (c_q.cost > rd_q) ? c_q.cost : rd_q;
			end else begin
				od_q.cell_index <= '0;
				od_q.cell_value <= '0;
			end
		end
	end
endmodule

// ----- hdl/occupancy_grid_max_fusion.sv -----
// ----------------------------------------------------------------------------
// occupancy_grid_max_fusion
// merges local costmap cells into a global grid by maximum, serves reads
// ----------------------------------------------------------------------------
// A request passes through the transform steps of the front part (cell
// centre, rotation multiplies, translation, origin offset, scaling by
// partial products, bounds check, index multiply), a two-entry command
// queue, a read of the single-port global store in the back part, and the
// write of the merged cost back for merges along with the result register.
// The front part takes a new request only after its last command has gone
// into the queue; the back part takes a new command only after its last
// result has been taken. After reset the store is cleared one cell a cycle,
// all 65536 cells, during which requests wait; configuration writes are
// taken at any time.
module occupancy_grid_max_fusion import ogmf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	ogmf_cfg_if.sink   cfg_ch,
	ogmf_req_if.sink   req,
	ogmf_res_if.source res
);
	cfg_t cfg_q;

	// configuration registers, always ready
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.global_width           <= 9'd256;
			cfg_q.global_height          <= 9'd256;
			cfg_q.global_origin_x        <= '0;
			cfg_q.global_origin_y        <= '0;
			cfg_q.global_cells_per_meter <= 32'd655360;
			cfg_q.local_resolution       <= 32'd6554;
			cfg_q.loc_org_x              <= '0;
			cfg_q.loc_org_y              <= '0;
		end else if (cfg_ch.valid) begin
			unique case (cfg_idx_t'(cfg_ch.index))
				CFG_WIDTH:  cfg_q.global_width           <= cfg_ch.wdata[8:0];
				CFG_HEIGHT: cfg_q.global_height          <= cfg_ch.wdata[8:0];
				CFG_GORG_X: cfg_q.global_origin_x        <= cfg_ch.wdata;
				CFG_GORG_Y: cfg_q.global_origin_y        <= cfg_ch.wdata;
				CFG_CPM:    cfg_q.global_cells_per_meter <= cfg_ch.wdata;
				CFG_LRES:   cfg_q.local_resolution       <= cfg_ch.wdata;
				CFG_LORG_X: cfg_q.loc_org_x              <= cfg_ch.wdata;
				default:    cfg_q.loc_org_y              <= cfg_ch.wdata;
			endcase
		end
	end

	// front part, gated while the store is cleared
	logic clr_busy;
	logic f_in_ready, f_valid, f_ready;
	cmd_t f_cmd;
	logic [15:0] f_ridx;

	assign req.ready = f_in_ready && !clr_busy;

	ogmf_front u_front (
		.clk, .arst_n, .cfg(cfg_q),
		.in_valid(req.valid && !clr_busy), .in_ready(f_in_ready), .in_data(req.data),
		.out_valid(f_valid), .out_ready(f_ready), .out_cmd(f_cmd), .out_ridx(f_ridx)
	);

	// two-entry command queue between front and back
	cmd_t        qc_q [2];
	logic [15:0] qr_q [2];
	logic [1:0]  cnt_q;
	logic        wp_q, rp_q;
	logic        b_ready;
	logic        push, pop;

	assign f_ready = (cnt_q != 2'd2);
	assign push    = f_valid && f_ready;
	assign pop     = (cnt_q != 2'd0) && b_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			qc_q[wp_q] <= f_cmd;
			qr_q[wp_q] <= f_ridx;
		end
	end

	// back part: store and result register
	ogmf_back u_back (
		.clk, .arst_n, .clr_busy,
		.in_valid(cnt_q != 2'd0), .in_ready(b_ready),
		.in_cmd(qc_q[rp_q]), .in_ridx(qr_q[rp_q]),
		.out_valid(res.valid), .out_ready(res.ready), .out_data(res.data)
	);
endmodule

// ----- tb/ogmf_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ogmf_tb_pkg
// grid fusion predictor: transform, quantize and max-merge into a shadow map
// ----------------------------------------------------------------------------
package ogmf_tb_pkg;
	import ogmf_pkg::*;

	cfg_t           grid_cfg;
	logic [6:0]     shadow_map [Cells];

	function automatic void shadow_reset();
		grid_cfg.global_width           = 9'd256;
		grid_cfg.global_height          = 9'd256;
		grid_cfg.global_origin_x        = '0;
		grid_cfg.global_origin_y        = '0;
		grid_cfg.global_cells_per_meter = 32'd655360;
		grid_cfg.local_resolution       = 32'd6554;
		grid_cfg.loc_org_x              = '0;
		grid_cfg.loc_org_y              = '0;
		foreach (shadow_map[i]) shadow_map[i] = '0;
	endfunction

	function automatic void shadow_config(cfg_idx_t sel, logic [31:0] v);
		case (sel)
			CFG_WIDTH:  grid_cfg.global_width = v[8:0];
			CFG_HEIGHT: grid_cfg.global_height = v[8:0];
			CFG_GORG_X: grid_cfg.global_origin_x = v;
			CFG_GORG_Y: grid_cfg.global_origin_y = v;
			CFG_CPM:    grid_cfg.global_cells_per_meter = v;
			CFG_LRES:   grid_cfg.local_resolution = v;
			CFG_LORG_X: grid_cfg.loc_org_x = v;
			CFG_LORG_Y: grid_cfg.loc_org_y = v;
			default: ;
		endcase
	endfunction

	// exact 128-bit arithmetic; >>> on signed gives floor
	function automatic res_t fuse_cell(req_item_t it);
		res_t r;
		logic signed [127:0] lx, ly, wx, wy, dx, dy;
		logic [127:0] gx, gy, w, h, idx;
		r = '0;
		if (it.req_type == REQ_READ) begin
			r.cell_index = it.read_index;
			r.cell_value = shadow_map[it.read_index];
			return r;
		end
		if (it.cell_cost < 0) return r;
		lx = $signed(grid_cfg.loc_org_x) + $signed({1'b0,
			(({118'd0, it.local_col} * 2 + 1) * {96'd0, grid_cfg.local_resolution}) >> 1});
		ly = $signed(grid_cfg.loc_org_y) + $signed({1'b0,
			(({118'd0, it.local_row} * 2 + 1) * {96'd0, grid_cfg.local_resolution}) >> 1});
		wx = it.robot_x + ((lx * it.cos_heading - ly * it.sin_heading) >>> 14);
		wy = it.robot_y + ((lx * it.sin_heading + ly * it.cos_heading) >>> 14);
		if (wx < grid_cfg.global_origin_x || wy < grid_cfg.global_origin_y) return r;
		dx = wx - grid_cfg.global_origin_x;
		dy = wy - grid_cfg.global_origin_y;
		gx = (dx * {96'd0, grid_cfg.global_cells_per_meter}) >> 32;
		gy = (dy * {96'd0, grid_cfg.global_cells_per_meter}) >> 32;
		w = (grid_cfg.global_width < GridW) ? grid_cfg.global_width : GridW;
		h = (grid_cfg.global_height < GridH) ? grid_cfg.global_height : GridH;
		if (gx >= w || gy >= h) return r;
		idx = gy * w + gx;
		if (idx >= Cells) return r;
		if (it.cell_cost[6:0] > shadow_map[idx]) shadow_map[idx] = it.cell_cost[6:0];
		r.written    = 1'b1;
		r.cell_index = idx[15:0];
		r.cell_value = shadow_map[idx];
		return r;
	endfunction

endpackage

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives merges and reads through several grid settings and checks results
// ----------------------------------------------------------------------------
module testbench;
	import ogmf_pkg::*;
	import ogmf_tb_pkg::*;

	logic clk;
	logic arst_n;

	ogmf_cfg_if cfg_ch();
	ogmf_req_if req();
	ogmf_res_if res();

	occupancy_grid_max_fusion dut (
		.clk(clk), .arst_n(arst_n), .cfg_ch(cfg_ch), .req(req), .res(res)
	);

	always begin
		clk = 1'b0; #1;
		clk = 1'b1; #1;
	end

	req_item_t  pending_reqs [$];
	res_t       expected_cells [$];
	int         error_count = 0;
	int         cycle_count = 0;
	int         accepted_count = 0;
	int         seen_count = 0;
	bit         calm_phase = 0;  // no idling near the end
	bit         hold_reqs = 0;
	int         send_gap = 0;
	int         recv_gap = 0;
	localparam int CycleLimit = 1_500_000;

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("error: %s got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
		error_count++;
	endtask

	// request driver: a presented transaction stays until it is taken
	always @(negedge clk) begin
		bit waiting;
		waiting = req.valid && (accepted_count == seen_count);
		seen_count = accepted_count;
		if (send_gap > 0) send_gap--;
		else if (!calm_phase && $urandom_range(0, 19) == 0) send_gap = $urandom_range(1, 17);
		if (!waiting) begin
			if (pending_reqs.size() > 0 && send_gap == 0 && !hold_reqs) begin
				req.valid <= 1'b1;
				req.data  <= pending_reqs[0];
			end else begin
				req.valid <= 1'b0;
			end
		end
		if (recv_gap > 0) recv_gap--;
		else if (!calm_phase && $urandom_range(0, 19) == 0) recv_gap = $urandom_range(1, 17);
		res.ready <= (recv_gap == 0);
	end

	// result monitor; prediction at acceptance keeps map order right
	always @(posedge clk) begin
		res_t want;
		cycle_count <= cycle_count + 1;
		if (req.valid && req.ready) begin
			expected_cells.push_back(fuse_cell(req.data));
			void'(pending_reqs.pop_front());
			accepted_count++;
		end
		if (res.valid && res.ready) begin
			if (expected_cells.size() == 0) begin
				report("unexpected result", res.data, 0);
			end else begin
				want = expected_cells.pop_front();
				if (res.data.written !== want.written)
					report("written", res.data.written, want.written);
				if (res.data.cell_index !== want.cell_index)
					report("cell_index", res.data.cell_index, want.cell_index);
				if (res.data.cell_value !== want.cell_value)
					report("cell_value", res.data.cell_value, want.cell_value);
			end
		end
		if (cycle_count > CycleLimit) begin
			$display("occupancy_grid_max_fusion: mismatch");
			$finish;
		end
	end

	// config write, only while idle
	task automatic write_reg(cfg_idx_t sel, logic [31:0] v);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= sel;
		cfg_ch.wdata <= v;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		shadow_config(sel, v);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || expected_cells.size() > 0 || req.valid)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic req_item_t merge_item(int c, int r, int cost, int rx, int ry,
			int cs, int sn);
		req_item_t it;
		it = '0;
		it.req_type = REQ_MERGE;
		it.local_col = 10'(c); it.local_row = 10'(r); it.cell_cost = 8'(cost);
		it.robot_x = rx; it.robot_y = ry;
		it.cos_heading = 16'(cs); it.sin_heading = 16'(sn);
		it.read_index = 16'($urandom);
		return it;
	endfunction

	function automatic req_item_t read_item(int ix);
		req_item_t it;
		it = '0;
		it.req_type = REQ_READ;
		it.read_index = 16'(ix);
		it.local_col = 10'($urandom); it.local_row = 10'($urandom);
		return it;
	endfunction

	// mostly in-grid poses, some wild ones
	function automatic req_item_t rand_item(bit wide);
		req_item_t it;
		int ang;
		if ($urandom_range(0, 4) == 0) return read_item($urandom_range(0, 65535));
		ang = $urandom_range(0, 3);
		it = merge_item($urandom_range(0, wide ? 1023 : 60), $urandom_range(0, wide ? 1023 : 60),
			$urandom_range(0, 9) == 0 ? -$urandom_range(1, 128) : $urandom_range(0, 127),
			wide ? $urandom : $urandom_range(0, 20 << 16),
			wide ? $urandom : $urandom_range(0, 20 << 16),
			ang == 0 ? 16384 : ang == 1 ? -16384 : $urandom_range(0, 32768) - 16384,
			ang == 2 ? 16384 : ang == 3 ? 0 : $urandom_range(0, 32768) - 16384);
		if ($urandom_range(0, 7) == 0) begin
			it.robot_x = $urandom; it.robot_y = $urandom;
			it.cos_heading = 16'($urandom); it.sin_heading = 16'($urandom);
		end
		return it;
	endfunction

	initial begin
		int n;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0; cfg_ch.index = CFG_WIDTH; cfg_ch.wdata = '0;
		req.valid = 1'b0; req.data = '0;
		res.ready = 1'b0;
		shadow_reset();
		repeat (3) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: extremes, unknown cost, out of grid, reads
		pending_reqs.push_back(merge_item(0, 0, 127, 0, 0, 16384, 0));
		pending_reqs.push_back(merge_item(0, 0, 5, 0, 0, 16384, 0));
		pending_reqs.push_back(merge_item(1023, 1023, 100, 0, 0, 16384, 0));
		pending_reqs.push_back(merge_item(3, 4, -1, 0, 0, 16384, 0));
		pending_reqs.push_back(merge_item(3, 4, -128, 0, 0, 16384, 0));
		pending_reqs.push_back(merge_item(3, 4, 0, 0, 0, 16384, 0));
		pending_reqs.push_back(merge_item(10, 2, 60, 32'h7fffffff, 32'h7fffffff, -16384, -16384));
		pending_reqs.push_back(merge_item(10, 2, 60, 32'h80000000, 32'h80000000, 16384, 16384));
		pending_reqs.push_back(merge_item(700, 300, 90, 0, 0, 0, 16384));
		pending_reqs.push_back(merge_item(5, 5, 77, 5 << 16, 5 << 16, -16384, 0));
		pending_reqs.push_back(merge_item(5, 5, 33, 10 << 16, 3 << 16, 11585, 11585));
		pending_reqs.push_back(merge_item(255, 255, 126, 2 << 16, 2 << 16, 16384, 0));
		pending_reqs.push_back(read_item(0));
		pending_reqs.push_back(read_item(65535));
		pending_reqs.push_back(read_item(2570));
		pending_reqs.push_back(read_item(50));
		drain();

		// pressure: sender held mid-batch until all results are back
		for (n = 0; n < 150; n++) pending_reqs.push_back(rand_item(n % 9 == 0));
		repeat (200) @(posedge clk);
		hold_reqs = 1;
		while (expected_cells.size() > 0) @(posedge clk);
		hold_reqs = 0;
		drain();

		// small grid, shifted origins, coarse resolution
		write_reg(CFG_WIDTH, 9'd1);
		write_reg(CFG_HEIGHT, 9'd7);
		write_reg(CFG_GORG_X, -(3 << 16));
		write_reg(CFG_GORG_Y, 32'h80000000);
		write_reg(CFG_CPM, 32'd65536);
		write_reg(CFG_LRES, 32'd32768);
		write_reg(CFG_LORG_X, -(2 << 16));
		write_reg(CFG_LORG_Y, 32'h7fffffff);
		for (n = 0; n < 100; n++) pending_reqs.push_back(rand_item(n % 5 == 0));
		drain();

		// extreme register values, oversized and zero sizes
		write_reg(CFG_WIDTH, 9'd511);
		write_reg(CFG_HEIGHT, 9'd0);
		write_reg(CFG_CPM, 32'hffffffff);
		write_reg(CFG_LRES, 32'hffffffff);
		write_reg(CFG_GORG_X, 32'h7fffffff);
		write_reg(CFG_GORG_Y, 32'h80000000);
		write_reg(CFG_LORG_X, 32'h80000000);
		write_reg(CFG_LORG_Y, '0);
		for (n = 0; n < 60; n++) pending_reqs.push_back(rand_item(1));
		drain();

		write_reg(CFG_WIDTH, 9'd300);
		write_reg(CFG_HEIGHT, 9'd256);
		write_reg(CFG_GORG_X, '0);
		write_reg(CFG_GORG_Y, '0);
		write_reg(CFG_CPM, 32'd1);
		write_reg(CFG_LRES, 32'd1);
		for (n = 0; n < 60; n++) pending_reqs.push_back(rand_item(1));
		drain();

		// mid settings, long random run, last part with no idling
		write_reg(CFG_WIDTH, 9'd100);
		write_reg(CFG_HEIGHT, 9'd40);
		write_reg(CFG_CPM, 32'd327680);
		write_reg(CFG_LRES, 32'd13107);
		write_reg(CFG_LORG_X, -(1 << 16));
		write_reg(CFG_LORG_Y, -(1 << 16));
		for (n = 0; n < 150; n++) pending_reqs.push_back(rand_item(n % 10 == 0));
		drain();
		calm_phase = 1;
		for (n = 0; n < 100; n++) pending_reqs.push_back(rand_item(n % 10 == 0));
		drain();

		if (error_count == 0) begin
			$display("occupancy_grid_max_fusion: match");
		end else begin
			$display("occupancy_grid_max_fusion: mismatch");
		end
		$finish;
	end

endmodule
